FILE: hw/rtl/mme_pkg.sv
package mme_pkg;

	localparam int DEF_MAX_DIM   = 8;
	localparam int DEF_ELEM_BITS = 16;
	localparam int DIM_BITS      = 4;
	localparam int IN_IDX_BITS   = 3;
	localparam int VAL_BITS      = 16;
	localparam int SUM_BITS      = 35;
	localparam int ADDR_BITS     = 4;
	localparam logic [DIM_BITS-1:0] DIM_RESET = 4'd8;

	typedef enum logic [1:0] {
		FUNC_LOAD_A,
		FUNC_LOAD_B,
		FUNC_COMPUTE
	} func_t;

	typedef enum logic [1:0] {
		REG_ROWS_OF_A,
		REG_INNER_DIM,
		REG_COLS_OF_B
	} reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} issue_t;

	typedef struct packed {
		logic a_we;
		logic b_we;
	} wen_t;

endpackage

FILE: hw/rtl/matrix_multiply_engine.sv
// channel   | dir | handshake                  | payload
// s         | in  | s_tvalid / s_tready        | s_tuser func, s_tdata row, col, value
// m         | out | m_tvalid / m_tready        | m_tdata row, col, dot sum; m_tlast
// apb       | in  | psel & penable & pwrite    | paddr, pwdata, prdata
//
// a load item is written to its store when accepted; loads outside the set dimensions are dropped
// a compute item is worked element by element on one shared multiply-accumulate:
// the accept, then per element n reads issued, the read and multiply pipeline
// draining, and the element held on m until it is taken
// s_tready is low from a compute item until its last element is taken
// arst_n clears control state only; the element stores are not cleared
module matrix_multiply_engine #(
	parameter int MAX_DIM   = mme_pkg::DEF_MAX_DIM,
	parameter int ELEM_BITS = mme_pkg::DEF_ELEM_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata, // row_index, col_index, elem_value
	input  logic [1:0]                      s_tuser, // func
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [47:0]                     m_tdata, // out_row, out_col, dot_sum
	output logic                            m_tlast,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mme_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	import mme_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	logic [DIM_BITS-1:0]        rows_q;
	logic [DIM_BITS-1:0]        inner_q;
	logic [DIM_BITS-1:0]        cols_q;
	logic [IDX_W-1:0]           last_m;
	logic [IDX_W-1:0]           last_n;
	logic [IDX_W-1:0]           last_p;
	logic                       cfg_we;
	wen_t                       wen;
	issue_t                     issue;
	logic [AW-1:0]              wr_addr;
	logic [AW-1:0]              rd_a_addr;
	logic [AW-1:0]              rd_b_addr;
	logic [ELEM_BITS-1:0]       wdata;
	logic [ELEM_BITS-1:0]       a_rd;
	logic [ELEM_BITS-1:0]       b_rd;
	logic signed [SUM_BITS-1:0] acc;
	logic                       mac_done;
	logic [IN_IDX_BITS-1:0]     out_row;
	logic [IN_IDX_BITS-1:0]     out_col;
	logic                       out_last;

	function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_BITS-1:0] d);
		int v;
		v = int'(d);
		if (v == 0) begin
			v = 1;
		end else if (v > MAX_DIM) begin
			v = MAX_DIM;
		end
		return IDX_W'(v - 1);
	endfunction

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			cols_q  <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (reg_t'(paddr[3:2]))
				REG_ROWS_OF_A: rows_q  <= pwdata[DIM_BITS-1:0];
				REG_INNER_DIM: inner_q <= pwdata[DIM_BITS-1:0];
				REG_COLS_OF_B: cols_q  <= pwdata[DIM_BITS-1:0];
				default:       rows_q  <= rows_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_t'(paddr[3:2]))
			REG_ROWS_OF_A: prdata = 32'(rows_q);
			REG_INNER_DIM: prdata = 32'(inner_q);
			REG_COLS_OF_B: prdata = 32'(cols_q);
			default:       prdata = '0;
		endcase
	end

	assign last_m = last_idx(rows_q);
	assign last_n = last_idx(inner_q);
	assign last_p = last_idx(cols_q);
	assign wdata  = ELEM_BITS'(s_tdata[21:6]);

	mme_seq #(
		.MAX_DIM (MAX_DIM)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.func      (s_tuser),
		.row_in    (s_tdata[2:0]),
		.col_in    (s_tdata[5:3]),
		.last_m    (last_m),
		.last_n    (last_n),
		.last_p    (last_p),
		.mac_done  (mac_done),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.wen       (wen),
		.wr_addr   (wr_addr),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.issue     (issue),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (out_last)
	);

	mme_store #(
		.DEPTH (DEPTH),
		.WIDTH (ELEM_BITS)
	) u_a_store (
		.clk   (clk),
		.we    (wen.a_we),
		.waddr (wr_addr),
		.wdata (wdata),
		.raddr (rd_a_addr),
		.rdata (a_rd)
	);

	mme_store #(
		.DEPTH (DEPTH),
		.WIDTH (ELEM_BITS)
	) u_b_store (
		.clk   (clk),
		.we    (wen.b_we),
		.waddr (wr_addr),
		.wdata (wdata),
		.raddr (rd_b_addr),
		.rdata (b_rd)
	);

	mme_mac #(
		.ELEM_BITS (ELEM_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.a_rd   (a_rd),
		.b_rd   (b_rd),
		.acc    (acc),
		.done   (mac_done)
	);

	assign m_tdata = {7'b0, acc, out_col, out_row};
	assign m_tlast = out_last;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	a_compute_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == FUNC_COMPUTE) |=> !s_tready)
		else $error("compute item did not stall the input");

	a_emit_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(mac_done))
		else $error("result shown before accumulation finished");

	a_no_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !issue.vld)
		else $error("multiply issued while idle");

endmodule

FILE: hw/rtl/mme_store.sv
module mme_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/mme_mac.sv
module mme_mac #(
	parameter int ELEM_BITS = mme_pkg::DEF_ELEM_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mme_pkg::issue_t                    issue,
	input  logic signed [ELEM_BITS-1:0]        a_rd,
	input  logic signed [ELEM_BITS-1:0]        b_rd,
	output logic signed [mme_pkg::SUM_BITS-1:0] acc,
	output logic                               done
);

	import mme_pkg::*;

	issue_t                        tag_s1;
	issue_t                        tag_s2;
	logic signed [2*ELEM_BITS-1:0] prod_s2;
	logic signed [SUM_BITS-1:0]    acc_q;
	logic                          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
			done_q <= tag_s2.vld && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd * b_rd;
		if (tag_s2.vld) begin
			if (tag_s2.first) begin
				acc_q <= SUM_BITS'(prod_s2);
			end else begin
				acc_q <= acc_q + SUM_BITS'(prod_s2);
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

FILE: hw/rtl/mme_seq.sv
module mme_seq #(
	parameter int MAX_DIM = mme_pkg::DEF_MAX_DIM
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [1:0]                            func,
	input  logic [mme_pkg::IN_IDX_BITS-1:0]       row_in,
	input  logic [mme_pkg::IN_IDX_BITS-1:0]       col_in,
	input  logic [$clog2(MAX_DIM)-1:0]            last_m,
	input  logic [$clog2(MAX_DIM)-1:0]            last_n,
	input  logic [$clog2(MAX_DIM)-1:0]            last_p,
	input  logic                                  mac_done,
	input  logic                                  m_tready,
	output logic                                  m_tvalid,
	output mme_pkg::wen_t                         wen,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    wr_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_a_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_b_addr,
	output mme_pkg::issue_t                       issue,
	output logic [mme_pkg::IN_IDX_BITS-1:0]       out_row,
	output logic [mme_pkg::IN_IDX_BITS-1:0]       out_col,
	output logic                                  out_last
);

	import mme_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int AW    = $clog2(MAX_DIM * MAX_DIM);

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] r_q;
	logic [IDX_W-1:0] c_q;
	logic [IDX_W-1:0] k_q;
	logic             accept;
	logic             row_in_a;
	logic             col_in_a;
	logic             row_in_b;
	logic             col_in_b;
	logic             c_end;
	logic             r_end;

	assign accept   = s_tvalid && s_tready;
	assign row_in_a = int'(row_in) <= int'(last_m);
	assign col_in_a = int'(col_in) <= int'(last_n);
	assign row_in_b = int'(row_in) <= int'(last_n);
	assign col_in_b = int'(col_in) <= int'(last_p);
	assign c_end    = c_q == last_p;
	assign r_end    = r_q == last_m;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func_t'(func) == FUNC_COMPUTE) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (k_q == last_n) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (mac_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (m_tready) begin
					state_d = (c_end && r_end) ? ST_IDLE : ST_RUN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		wen         = '0;
		issue       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				case (func_t'(func))
					FUNC_LOAD_A: wen.a_we = s_tvalid && row_in_a && col_in_a;
					FUNC_LOAD_B: wen.b_we = s_tvalid && row_in_b && col_in_b;
					default:     wen      = '0;
				endcase
			end
			ST_RUN: begin
				issue.vld   = 1'b1;
				issue.first = k_q == '0;
				issue.last  = k_q == last_n;
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign wr_addr   = AW'(int'(row_in) * MAX_DIM + int'(col_in));
	assign rd_a_addr = AW'(int'(r_q) * MAX_DIM + int'(k_q));
	assign rd_b_addr = AW'(int'(k_q) * MAX_DIM + int'(c_q));
	assign out_row   = IN_IDX_BITS'(r_q);
	assign out_col   = IN_IDX_BITS'(c_q);
	assign out_last  = c_end && r_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					r_q <= '0;
					c_q <= '0;
					k_q <= '0;
				end
				ST_RUN: begin
					k_q <= (k_q == last_n) ? '0 : k_q + 1'b1;
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (c_end) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				default: begin
					k_q <= '0;
				end
			endcase
		end
	end

endmodule

FILE: test/product_checker.sv
`timescale 1ns / 1ps

module product_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [23:0]                   s_tdata, // row_index, col_index, elem_value
	input  logic [1:0]                    s_tuser, // func
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [47:0]                   m_tdata, // out_row, out_col, dot_sum
	input  logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [mme_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output int                            fail_count,
	output int                            outstanding
);

	import mme_pkg::*;

	localparam int DIM = DEF_MAX_DIM;

	typedef struct packed {
		logic [2:0]          row;
		logic [2:0]          col;
		logic [SUM_BITS-1:0] dot_sum;
		logic                last_elem;
	} c_elem_t;

	c_elem_t             c_expected_q[$];
	logic [VAL_BITS-1:0] a_mem [DIM*DIM];
	logic [VAL_BITS-1:0] b_mem [DIM*DIM];
	logic [DIM_BITS-1:0] dim_reg [3];

	function automatic int clamp_dim(logic [DIM_BITS-1:0] v);
		if (v == 0)
			return 1;
		if (int'(v) > DIM)
			return DIM;
		return int'(v);
	endfunction

	// every element of C, row-major, full inner dimension
	task automatic push_product();
		int m, n, p;
		logic signed [SUM_BITS-1:0] acc;
		logic signed [VAL_BITS-1:0] x, y;
		c_elem_t e;
		m = clamp_dim(dim_reg[REG_ROWS_OF_A]);
		n = clamp_dim(dim_reg[REG_INNER_DIM]);
		p = clamp_dim(dim_reg[REG_COLS_OF_B]);
		for (int r = 0; r < m; r++) begin
			for (int c = 0; c < p; c++) begin
				acc = '0;
				for (int k = 0; k < n; k++) begin
					x = a_mem[r*DIM + k];
					y = b_mem[k*DIM + c];
					acc = acc + x * y;
				end
				e.row = 3'(r);
				e.col = 3'(c);
				e.dot_sum = acc;
				e.last_elem = (r == m - 1) && (c == p - 1);
				c_expected_q.push_back(e);
			end
		end
	endtask

	task automatic check_result();
		c_elem_t got, want;
		got.row = m_tdata[2:0];
		got.col = m_tdata[5:3];
		got.dot_sum = m_tdata[SUM_BITS+5:6];
		got.last_elem = m_tlast;
		if (c_expected_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: item out with nothing expected: row %0d col %0d sum %0d last %0b",
					$time, got.row, got.col, $signed(got.dot_sum), got.last_elem);
			return;
		end
		want = c_expected_q.pop_front();
		if (got.row !== want.row || got.col !== want.col ||
				got.dot_sum !== want.dot_sum || got.last_elem !== want.last_elem) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: got row %0d col %0d sum %0d last %0b, want row %0d col %0d sum %0d last %0b",
					$time, got.row, got.col, $signed(got.dot_sum), got.last_elem,
					want.row, want.col, $signed(want.dot_sum), want.last_elem);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_expected_q.delete();
			for (int i = 0; i < 3; i++)
				dim_reg[i] = DIM_RESET;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_BITS-1:2])
					REG_ROWS_OF_A, REG_INNER_DIM, REG_COLS_OF_B: begin
						dim_reg[paddr[ADDR_BITS-1:2]] = pwdata[DIM_BITS-1:0];
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					FUNC_LOAD_A: begin
						if (s_tdata[2:0] < clamp_dim(dim_reg[REG_ROWS_OF_A]) &&
								s_tdata[5:3] < clamp_dim(dim_reg[REG_INNER_DIM]))
							a_mem[s_tdata[2:0]*DIM + s_tdata[5:3]] = s_tdata[21:6];
					end
					FUNC_LOAD_B: begin
						if (s_tdata[2:0] < clamp_dim(dim_reg[REG_INNER_DIM]) &&
								s_tdata[5:3] < clamp_dim(dim_reg[REG_COLS_OF_B]))
							b_mem[s_tdata[2:0]*DIM + s_tdata[5:3]] = s_tdata[21:6];
					end
					FUNC_COMPUTE: begin
						push_product();
					end
					default: ;
				endcase
			end
			outstanding = c_expected_q.size();
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import mme_pkg::*;

	localparam int DIM = DEF_MAX_DIM;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 320;
	localparam int SETTLE_CYCLES = 8;
	localparam int STUCK_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0; // row_index, col_index, elem_value
	logic [1:0] s_tuser = '0; // func
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata; // out_row, out_col, dot_sum
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int fail_count;
	int outstanding;

	logic [DIM_BITS-1:0] dim_set [3];
	bit a_written [DIM*DIM];
	bit b_written [DIM*DIM];
	int stored_items;
	bit tx_steady;
	bit rx_steady;
	int stall_left;
	int stuck_cycles;

	matrix_multiply_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	product_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_dim(logic [DIM_BITS-1:0] v);
		if (v == 0)
			return 1;
		if (int'(v) > DIM)
			return DIM;
		return int'(v);
	endfunction

	function automatic logic [DIM_BITS-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 4'($urandom_range(1, 3));
		if (r < 65)
			return 4'($urandom_range(4, 7));
		if (r < 80)
			return 4'(DIM);
		if (r < 90)
			return 4'd0;
		return 4'($urandom_range(9, 15));
	endfunction

	function automatic logic [VAL_BITS-1:0] pick_value();
		if ($urandom_range(0, 6) == 0) begin
			case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h0000;
				default: return 16'hffff;
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic int pick_gap();
		int r;
		if (tx_steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		if (rx_steady) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else if ($urandom_range(0, 99) < 70) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic write_reg(reg_t idx, logic [DIM_BITS-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		dim_set[idx] = val;
	endtask

	task automatic send_item(logic [1:0] f, logic [2:0] row, logic [2:0] col,
			logic [VAL_BITS-1:0] val);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {2'b00, val, col, row};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_load(logic [1:0] f, logic [2:0] row, logic [2:0] col,
			logic [VAL_BITS-1:0] val);
		int m, n, p;
		m = eff_dim(dim_set[REG_ROWS_OF_A]);
		n = eff_dim(dim_set[REG_INNER_DIM]);
		p = eff_dim(dim_set[REG_COLS_OF_B]);
		if (f == FUNC_LOAD_A && row < m && col < n) begin
			a_written[row*DIM + col] = 1'b1;
			stored_items++;
		end else if (f == FUNC_LOAD_B && row < n && col < p) begin
			b_written[row*DIM + col] = 1'b1;
			stored_items++;
		end
		send_item(f, row, col, val);
	endtask

	task automatic send_compute();
		stored_items++;
		send_item(FUNC_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_noise();
		logic [1:0] f;
		case ($urandom_range(0, 2))
			0: f = FUNC_LOAD_A;
			1: f = FUNC_LOAD_B;
			default: f = FUNC_UNUSED;
		endcase
		send_load(f, 3'($urandom), 3'($urandom), 16'($urandom));
	endtask

	// fills every entry a compute will read, reloads some of the rest
	task automatic load_matrix(logic [1:0] f, int rows, int cols);
		bit seen;
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				seen = (f == FUNC_LOAD_A) ? a_written[r*DIM + c] : b_written[r*DIM + c];
				if (!seen || $urandom_range(0, 2) == 0) begin
					if ($urandom_range(0, 9) == 0)
						send_noise();
					send_load(f, 3'(r), 3'(c), pick_value());
				end
			end
		end
	endtask

	task automatic run_sequence(bit reconfig);
		int m, n, p;
		bit b_first;
		if (reconfig) begin
			wait_drained();
			write_reg(REG_ROWS_OF_A, pick_dim());
			write_reg(REG_INNER_DIM, pick_dim());
			write_reg(REG_COLS_OF_B, pick_dim());
		end
		tx_steady = ($urandom_range(0, 4) == 0);
		rx_steady = ($urandom_range(0, 4) == 0);
		m = eff_dim(dim_set[REG_ROWS_OF_A]);
		n = eff_dim(dim_set[REG_INNER_DIM]);
		p = eff_dim(dim_set[REG_COLS_OF_B]);
		b_first = 1'($urandom_range(0, 1));
		if (b_first)
			load_matrix(FUNC_LOAD_B, n, p);
		load_matrix(FUNC_LOAD_A, m, n);
		if (!b_first)
			load_matrix(FUNC_LOAD_B, n, p);
		if ($urandom_range(0, 5) == 0)
			send_noise();
		send_compute();
		if ($urandom_range(0, 3) == 0)
			send_compute();
		if ($urandom_range(0, 3) == 0)
			wait_drained();
	endtask

	initial begin
		bit first;
		for (int i = 0; i < 3; i++)
			dim_set[i] = DIM_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 2x2x2 with extreme elements, out-of-range loads and the unused code
		write_reg(REG_ROWS_OF_A, 4'd2);
		write_reg(REG_INNER_DIM, 4'd2);
		write_reg(REG_COLS_OF_B, 4'd2);
		send_load(FUNC_LOAD_A, 3'd0, 3'd0, 16'h8000);
		send_load(FUNC_LOAD_A, 3'd0, 3'd1, 16'h8000);
		send_load(FUNC_LOAD_A, 3'd1, 3'd0, 16'h7fff);
		send_load(FUNC_LOAD_A, 3'd1, 3'd1, 16'hffff);
		send_load(FUNC_LOAD_B, 3'd0, 3'd0, 16'h8000);
		send_load(FUNC_LOAD_B, 3'd1, 3'd0, 16'h8000);
		send_load(FUNC_LOAD_B, 3'd0, 3'd1, 16'h7fff);
		send_load(FUNC_LOAD_B, 3'd1, 3'd1, 16'h0001);
		send_load(FUNC_LOAD_A, 3'd7, 3'd7, 16'h1234);
		send_load(FUNC_LOAD_B, 3'd2, 3'd0, 16'h5555);
		send_load(FUNC_UNUSED, 3'd7, 3'd7, 16'hffff);
		send_compute();

		// zero dimension acts as one
		wait_drained();
		write_reg(REG_ROWS_OF_A, 4'd0);
		write_reg(REG_INNER_DIM, 4'd1);
		write_reg(REG_COLS_OF_B, 4'd1);
		send_load(FUNC_LOAD_B, 3'd0, 3'd0, 16'h7fff);
		send_compute();

		stored_items = 0;
		first = 1'b1;
		while (stored_items < RANDOM_ITEMS) begin
			run_sequence(first || $urandom_range(0, 1) == 1);
			first = 1'b0;
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
